FILE: rtl/core/tlpc_pkg.sv
// Shared constants and types for the two-line point cover check.
`default_nettype none

package tlpc_pkg;

	// Coordinate width used by default; fields on the bus are always 32 bits wide
	localparam int COORD_BITS_DEF = 32;

	// Stream bus layout
	localparam int FIELD_W  = 32;
	localparam int Y_LSB    = FIELD_W;
	localparam int S_DATA_W = 2 * FIELD_W;
	localparam int M_DATA_W = 8;

	// Point counter codes (saturates at three)
	localparam logic [1:0] SEEN_NONE  = 2'd0;
	localparam logic [1:0] SEEN_THIRD = 2'd2;
	localparam logic [1:0] SEEN_FULL  = 2'd3;

	// Off-line points kept per lane
	localparam logic [1:0] LEFT_MAX = 2'd2;

	// Per-lane control from the top level
	typedef struct packed {
		logic take;   // test the point on the lane's lines this cycle
		logic clear;  // end of set: drop lane state
	} lane_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/tlpc_online.sv
// Exact collinearity test: does point c lie on the line through a and b.
`default_nettype none

module tlpc_online #(
	parameter int COORD_BITS = tlpc_pkg::COORD_BITS_DEF
) (
	input  wire logic signed [COORD_BITS-1:0] ax,
	input  wire logic signed [COORD_BITS-1:0] ay,
	input  wire logic signed [COORD_BITS-1:0] bx,
	input  wire logic signed [COORD_BITS-1:0] by,
	input  wire logic signed [COORD_BITS-1:0] cx,
	input  wire logic signed [COORD_BITS-1:0] cy,
	output logic                              on_line
);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0] vx, vy, wx, wy;
	logic signed [PW-1:0] p_lhs, p_rhs;

	// Difference vectors, one bit wider so they never wrap
	assign vx = DW'(ax) - DW'(bx);
	assign vy = DW'(ay) - DW'(by);
	assign wx = DW'(ax) - DW'(cx);
	assign wy = DW'(ay) - DW'(cy);

	// Full-width cross product terms; equal means collinear
	assign p_lhs = PW'(vx) * PW'(wy);
	assign p_rhs = PW'(vy) * PW'(wx);
	assign on_line = (p_lhs == p_rhs);

endmodule

`default_nettype wire

FILE: rtl/core/tlpc_lane.sv
// One candidate lane: pair line test, two kept off-line points, fail flag.
`default_nettype none

module tlpc_lane #(
	parameter int COORD_BITS = tlpc_pkg::COORD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tlpc_pkg::lane_ctl_t               ctl,
	input  wire logic signed [COORD_BITS-1:0]      ax,
	input  wire logic signed [COORD_BITS-1:0]      ay,
	input  wire logic signed [COORD_BITS-1:0]      bx,
	input  wire logic signed [COORD_BITS-1:0]      by,
	input  wire logic signed [COORD_BITS-1:0]      cx,
	input  wire logic signed [COORD_BITS-1:0]      cy,
	output logic                                   fail_now
);
	import tlpc_pkg::*;

	logic signed [COORD_BITS-1:0] left_x_q [2];
	logic signed [COORD_BITS-1:0] left_y_q [2];
	logic [1:0] count_q;
	logic       failed_q;
	logic       on_pair, on_left, off_pair, keep, fail_new;

	// Test against the lane's own pair line
	tlpc_online #(.COORD_BITS(COORD_BITS)) u_pair (
		.ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy), .on_line(on_pair)
	);

	// Test against the line through the two kept points
	tlpc_online #(.COORD_BITS(COORD_BITS)) u_left (
		.ax(left_x_q[0]), .ay(left_y_q[0]), .bx(left_x_q[1]), .by(left_y_q[1]),
		.cx(cx), .cy(cy), .on_line(on_left)
	);

	assign off_pair = ctl.take && !on_pair;
	assign keep     = off_pair && (count_q != LEFT_MAX);
	assign fail_new = off_pair && (count_q == LEFT_MAX) && !on_left;
	assign fail_now = failed_q | fail_new;

	// Count and fail flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= SEEN_NONE;
			failed_q <= 1'b0;
		end else if (ctl.clear) begin
			count_q  <= SEEN_NONE;
			failed_q <= 1'b0;
		end else begin
			if (keep)
				count_q <= count_q + 2'd1;
			if (fail_new)
				failed_q <= 1'b1;
		end
	end

	// Kept points, in arrival order
	always_ff @(posedge clk) begin
		if (keep) begin
			left_x_q[count_q[0]] <= cx;
			left_y_q[count_q[0]] <= cy;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/two_line_point_cover_check.sv
// Two-line point cover check: top level with input register, lanes and result register.
// Points arrive one per beat on the slave stream; the beat with tlast set closes a set and
// produces one result beat whose bit 0 is 1 when two straight lines can hold every point of
// the set. Coordinates are taken from the low COORD_BITS bits of each 32-bit field as two's
// complement. The block takes one point per cycle unless a closing point waits on a held
// result: each point passes an input register, then a single stage of subtract, multiply
// and compare logic in three parallel lanes (one per pair of the first three points), then
// the result register, which takes the result beat as its closing point leaves the input
// register. Points keep flowing while a result waits; only a closing point waits for the
// result register to free up. Sets of up to three points report 1.
`default_nettype none

module two_line_point_cover_check #(
	parameter int COORD_BITS = tlpc_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// point_x [31:0], point_y [63:32]
	input  wire logic [tlpc_pkg::S_DATA_W-1:0] s_axis_tdata,
	input  wire logic                          s_axis_tlast,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// covered [0], zero fill [7:1]
	output logic [tlpc_pkg::M_DATA_W-1:0]      m_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready
);
	import tlpc_pkg::*;

	localparam int CB = COORD_BITS;

	logic                 valid_s1, last_s1;
	logic signed [CB-1:0] x_s1, y_s1;
	logic                 fire;

	logic [1:0]           seen_q;
	logic signed [CB-1:0] first_x_q [3];
	logic signed [CB-1:0] first_y_q [3];

	logic signed [CB-1:0] la_x [3], la_y [3], lb_x [3], lb_y [3], lc_x [3], lc_y [3];
	lane_ctl_t            ctl;
	logic [2:0]           fail_now;

	logic                 out_valid_q, covered_q;

	// Input register advances unless a closing point meets a held result
	assign fire          = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			x_s1    <= s_axis_tdata[CB-1:0];
			y_s1    <= s_axis_tdata[Y_LSB+CB-1:Y_LSB];
			last_s1 <= s_axis_tlast;
		end
	end

	// Point counter, saturating at three
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_q <= SEEN_NONE;
		else if (fire) begin
			if (last_s1)
				seen_q <= SEEN_NONE;
			else if (seen_q != SEEN_FULL)
				seen_q <= seen_q + 2'd1;
		end
	end

	// First three points
	always_ff @(posedge clk) begin
		if (fire && seen_q != SEEN_FULL) begin
			first_x_q[seen_q] <= x_s1;
			first_y_q[seen_q] <= y_s1;
		end
	end

	// Lane operands; on the third point each lane tests the point left out of its pair
	always_comb begin
		if (seen_q == SEEN_THIRD) begin
			la_x[0] = first_x_q[0]; la_y[0] = first_y_q[0];
			lb_x[0] = first_x_q[1]; lb_y[0] = first_y_q[1];
			lc_x[0] = x_s1;         lc_y[0] = y_s1;
			la_x[1] = first_x_q[0]; la_y[1] = first_y_q[0];
			lb_x[1] = x_s1;         lb_y[1] = y_s1;
			lc_x[1] = first_x_q[1]; lc_y[1] = first_y_q[1];
			la_x[2] = first_x_q[1]; la_y[2] = first_y_q[1];
			lb_x[2] = x_s1;         lb_y[2] = y_s1;
			lc_x[2] = first_x_q[0]; lc_y[2] = first_y_q[0];
		end else begin
			la_x[0] = first_x_q[0]; la_y[0] = first_y_q[0];
			lb_x[0] = first_x_q[1]; lb_y[0] = first_y_q[1];
			la_x[1] = first_x_q[0]; la_y[1] = first_y_q[0];
			lb_x[1] = first_x_q[2]; lb_y[1] = first_y_q[2];
			la_x[2] = first_x_q[1]; la_y[2] = first_y_q[1];
			lb_x[2] = first_x_q[2]; lb_y[2] = first_y_q[2];
			for (int i = 0; i < 3; i++) begin
				lc_x[i] = x_s1;
				lc_y[i] = y_s1;
			end
		end
	end

	assign ctl.take  = fire && (seen_q == SEEN_THIRD || seen_q == SEEN_FULL);
	assign ctl.clear = fire && last_s1;

	for (genvar g = 0; g < 3; g++) begin : g_lane
		tlpc_lane #(.COORD_BITS(CB)) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.ax      (la_x[g]),
			.ay      (la_y[g]),
			.bx      (lb_x[g]),
			.by      (lb_y[g]),
			.cx      (lc_x[g]),
			.cy      (lc_y[g]),
			.fail_now(fail_now[g])
		);
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire && last_s1)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1)
			covered_q <= (seen_q != SEEN_FULL) || !(&fail_now);
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_DATA_W-1){1'b0}}, covered_q};

endmodule

`default_nettype wire

FILE: rtl/core/tlpc_checker.sv
// Port-level checks for the two-line point cover check, bound to the top level.
`default_nettype none

module tlpc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_axis_tlast,
	input wire logic                          s_axis_tvalid,
	input wire logic                          s_axis_tready,
	input wire logic [tlpc_pkg::M_DATA_W-1:0] m_axis_tdata,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready
);
	// Held result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped or changed while stalled");

	// Only bit 0 of the result carries data
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[tlpc_pkg::M_DATA_W-1:1] == '0)
		else $error("result fill bits not zero");

	// With no result waiting, the block always takes a point
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result register");

	// A closing point yields a result once the result register is free
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) ##1
		(!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
		else $error("closing point gave no result");

endmodule

bind two_line_point_cover_check tlpc_checker u_tlpc_checker (.*);

`default_nettype wire
